[hdl/nfir_pkg.sv]
`timescale 1ns / 1ps

package nfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HIST_AW    = 3;
  localparam int HIST_DEPTH = 8;
  localparam int CFG_IDX_W  = 8;
  // sum of eight 16-bit signed weights
  localparam int WSUM_W     = 19;
  localparam int PROD_W     = 32;
  // |weight * sample| for a positive weight stays below 2**30
  localparam int MAG_W      = 30;
  localparam int DIVR_W     = 19;
  localparam int REM_W      = 20;
  localparam int DIV_STEPS  = 30;
  localparam int DIV_CNT_W  = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WSUM_W-1:0]   wsum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSUM,
    ST_CHECK,
    ST_READ,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    sample_t            wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } hist_req_t;

endpackage

[hdl/nfir_if.sv]
`timescale 1ns / 1ps

interface nfir_in_if;
  import nfir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface nfir_out_if;
  import nfir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    zero_weight_error;
  modport source (output valid, output sample_out, output zero_weight_error, input ready);
  modport sink (input valid, input sample_out, input zero_weight_error, output ready);
endinterface

interface nfir_cfg_if;
  import nfir_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  sample_t              wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[hdl/nfir_hist.sv]
`timescale 1ns / 1ps

module nfir_hist (
  input  logic                clk,
  input  logic                rst,
  input  nfir_pkg::hist_req_t req,
  output nfir_pkg::sample_t   rdata
);
  import nfir_pkg::*;

  sample_t               mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= vld[req.raddr] ? mem[req.raddr] : '0;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

endmodule

[hdl/nfir_div.sv]
`timescale 1ns / 1ps

module nfir_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  nfir_pkg::prod_t   dividend,
  input  nfir_pkg::wsum_t   divisor,
  output logic              done,
  output nfir_pkg::sample_t quo
);
  import nfir_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [MAG_W-1:0]     dvd;
  logic [DIVR_W-1:0]    dvr;
  logic [REM_W-1:0]     rem;
  logic [SAMPLE_W-1:0]  q;
  logic                 neg;

  logic [PROD_W-1:0] a_abs;
  logic [REM_W-1:0]  b_ext;
  logic [REM_W-1:0]  b_abs;
  logic [REM_W-1:0]  sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    a_abs = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
    b_ext = REM_W'(divisor);
    b_abs = divisor[WSUM_W-1] ? -b_ext : b_ext;
    sh    = {rem[REM_W-2:0], dvd[MAG_W-1]};
    trial = sh - {1'b0, dvr};
    ge    = !trial[REM_W-1];
    done  = busy && (step == '0);
    // only the low 16 bits of the truncated quotient reach the sum
    quo   = neg ? sample_t'(-q) : sample_t'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= a_abs[MAG_W-1:0];
      dvr <= b_abs[DIVR_W-1:0];
      rem <= '0;
      q   <= '0;
      neg <= dividend[PROD_W-1] ^ divisor[WSUM_W-1];
    end else if (busy && step != '0) begin
      rem <= ge ? trial : sh;
      q   <= {q[SAMPLE_W-2:0], ge};
      dvd <= {dvd[MAG_W-2:0], 1'b0};
    end
  end

endmodule

[hdl/normalized_fir_filter.sv]
`timescale 1ns / 1ps
// Normalized-gain FIR filter, one signed 16-bit sample in, one result out.
// upstream:   valid/ready request carrying sample_in.
// downstream: valid/ready request carrying sample_out and zero_weight_error.
// cfg:        valid/ready write of tap weight cfg.index (0..TAPS-1); other
//             indexes are dropped. ready is always high. Write only while idle.
// Each positive tap adds trunc(w*x/W), W being the sum of all TAPS weights;
// the sum wraps to 16 bits. W equal to zero gives 0 with the error flag set.
// The delay line is an 8-entry ring memory with registered reads.
// Each item runs the weight sum over all TAPS weights and a zero check;
// each positive tap then takes a memory read, a multiply and the 30-step
// serial divider, and each other tap is skipped. One item is worked on at
// a time.
// The result sits in an output register; the next sample is taken while it
// waits, and a stalled receiver holds the sequencer only at hand-off.
// Reset (synchronous, active high) clears the delay line to zeros, sets
// tap 0 to 1 and the other taps to 0, and empties the output register.
module normalized_fir_filter #(
  parameter int TAPS = 8
) (
  input  logic       clk,
  input  logic       rst,
  nfir_in_if.sink    upstream,
  nfir_out_if.source downstream,
  nfir_cfg_if.sink   cfg
);
  import nfir_pkg::*;

  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   cnt;
  logic [HIST_AW-1:0] ptr;
  wsum_t              wsum;
  sample_t            acc;
  prod_t              prod;
  sample_t            taps [TAPS];
  logic               out_valid;
  sample_t            out_sample;
  logic               out_err;

  sample_t   tap_sel;
  logic      tap_pos;
  logic      in_rdy;
  logic      out_load;
  logic      div_start;
  logic      div_done;
  sample_t   div_quo;
  sample_t   hist_rdata;
  hist_req_t hreq;

  nfir_hist u_hist (
    .clk   (clk),
    .rst   (rst),
    .req   (hreq),
    .rdata (hist_rdata)
  );

  nfir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (wsum),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign cfg.ready             = 1'b1;
  assign upstream.ready        = in_rdy;
  assign downstream.valid      = out_valid;
  assign downstream.sample_out = out_sample;
  assign downstream.zero_weight_error = out_err;

  assign tap_sel = taps[cnt];
  assign tap_pos = !tap_sel[SAMPLE_W-1] && (tap_sel != '0);

  always_comb begin
    state_next = state;
    hreq       = '0;
    div_start  = 1'b0;
    in_rdy     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (upstream.valid) begin
          hreq.we    = 1'b1;
          hreq.waddr = ptr + HIST_AW'(1);
          hreq.wdata = upstream.sample_in;
          state_next = ST_WSUM;
        end
      end
      ST_WSUM: begin
        if (cnt == LAST) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (wsum == '0) ? ST_OUT : ST_READ;
      end
      ST_READ: begin
        if (tap_pos) begin
          hreq.re    = 1'b1;
          hreq.raddr = ptr - HIST_AW'(cnt);
          state_next = ST_MUL;
        end else if (cnt == LAST) begin
          state_next = ST_OUT;
        end
      end
      ST_MUL: begin
        state_next = ST_DSTART;
      end
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = (cnt == LAST) ? ST_OUT : ST_READ;
      end
      ST_OUT: begin
        if (!out_valid || downstream.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        taps[i] <= (i == 0) ? sample_t'(1) : '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.index < CFG_IDX_W'(TAPS)) begin
        taps[cfg.index[IDX_W-1:0]] <= cfg.wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (downstream.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (upstream.valid) begin
            ptr <= ptr + HIST_AW'(1);
            cnt <= '0;
          end
        end
        ST_WSUM: begin
          cnt <= (cnt == LAST) ? '0 : cnt + IDX_W'(1);
        end
        ST_READ: begin
          if (!tap_pos && cnt != LAST) cnt <= cnt + IDX_W'(1);
        end
        ST_DIV: begin
          if (div_done && cnt != LAST) cnt <= cnt + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        wsum <= '0;
        acc  <= '0;
      end
      ST_WSUM: begin
        wsum <= wsum + wsum_t'(tap_sel);
      end
      ST_MUL: begin
        prod <= prod_t'(tap_sel) * prod_t'(hist_rdata);
      end
      ST_DIV: begin
        if (div_done) acc <= acc + div_quo;
      end
      ST_OUT: begin
        if (out_load) begin
          out_sample <= (wsum == '0) ? '0 : acc;
          out_err    <= (wsum == '0);
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_read_pos_tap: assert property (@(posedge clk) disable iff (rst)
    hreq.re |-> tap_pos && state == ST_READ)
    else $error("history read for a tap that is not positive");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    upstream.valid && upstream.ready |=> state == ST_WSUM && cnt == '0)
    else $error("accepted sample did not start the weight sum");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    downstream.valid && downstream.zero_weight_error |-> downstream.sample_out == '0)
    else $error("zero weight sum with nonzero output");
`endif

endmodule

[test/normalized_fir_filter_test.sv]
`timescale 1ns / 1ps

module normalized_fir_filter_test;
  import nfir_pkg::*;

  localparam int TAPS = 8;
  localparam int HIST_LEN = 7;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1900;
  localparam int MAX_REPORTS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TAP0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = 8'd255;

  typedef struct packed {
    sample_t value;
    logic    err;
  } filt_result_t;

  logic clk;
  logic rst;

  nfir_in_if  up_if ();
  nfir_out_if dn_if ();
  nfir_cfg_if cfg_if ();

  normalized_fir_filter #(.TAPS(TAPS)) uut (
    .clk(clk),
    .rst(rst),
    .upstream(up_if),
    .downstream(dn_if),
    .cfg(cfg_if)
  );

  // predictor state
  sample_t weights [TAPS];
  sample_t history [HIST_LEN];

  sample_t      samples_to_send [$];
  filt_result_t expected_out [$];

  logic steady;
  logic in_taken;
  int   n_errors;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic filt_result_t filter_sample(sample_t x);
    filt_result_t r;
    longint w_total;
    longint acc;
    longint xs;
    w_total = 0;
    acc = 0;
    for (int i = 0; i < TAPS; i++) w_total += weights[i];
    if (w_total == 0) begin
      r.value = '0;
      r.err = 1'b1;
    end else begin
      for (int s = 0; s < TAPS; s++) begin
        if (weights[s] > 0) begin
          if (s == 0) xs = x;
          else xs = history[s-1];
          // signed division truncates toward zero
          acc += (longint'(weights[s]) * xs) / w_total;
        end
      end
      r.value = sample_t'(acc[15:0]);
      r.err = 1'b0;
    end
    for (int i = HIST_LEN - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = x;
    return r;
  endfunction

  task automatic log_failure(string msg);
    if (n_errors < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // prediction on accepted requests, then checking of results
  always @(posedge clk) begin
    filt_result_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready && cfg_if.index < TAPS)
        weights[cfg_if.index] = cfg_if.wdata;
      if (up_if.valid && up_if.ready)
        expected_out.push_back(filter_sample(up_if.sample_in));
      if (dn_if.valid && dn_if.ready) begin
        if (expected_out.size() == 0) begin
          log_failure($sformatf("unexpected result sample_out=%0d err=%b",
                                dn_if.sample_out, dn_if.zero_weight_error));
        end else begin
          want = expected_out.pop_front();
          if (dn_if.sample_out !== want.value)
            log_failure($sformatf("sample_out exp %0d got %0d",
                                  want.value, dn_if.sample_out));
          if (dn_if.zero_weight_error !== want.err)
            log_failure($sformatf("zero_weight_error exp %b got %b",
                                  want.err, dn_if.zero_weight_error));
        end
      end
    end
    in_taken <= up_if.valid && up_if.ready;
  end

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      up_if.valid <= 1'b0;
    end else if (!up_if.valid || in_taken) begin
      if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
        up_if.sample_in <= samples_to_send.pop_front();
        up_if.valid <= 1'b1;
      end else begin
        up_if.valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    if (rst) dn_if.ready <= 1'b0;
    else dn_if.ready <= steady || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (rst || (up_if.valid && up_if.ready) || (dn_if.valid && dn_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input sample_t val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.wdata = val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic write_all_taps(input sample_t w [TAPS]);
    for (int i = 0; i < TAPS; i++) write_reg(REG_TAP0 + CFG_IDX_W'(i), w[i]);
  endtask

  // wait until every request went out and every result came back
  task automatic drain();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || up_if.valid || expected_out.size() != 0);
  endtask

  function automatic sample_t corner_value();
    case ($urandom_range(4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0001;
      3: return 16'shffff;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0: return corner_value();
      1, 2: return sample_t'(int'($urandom_range(512)) - 256);
      3: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic random_weights();
    sample_t w [TAPS];
    int total;
    total = 0;
    case ($urandom_range(5))
      0: for (int i = 0; i < TAPS; i++) w[i] = sample_t'($urandom);
      1: for (int i = 0; i < TAPS; i++) w[i] = sample_t'(int'($urandom_range(20)) - 4);
      2: begin
        // weights that cancel out exactly
        for (int i = 0; i < TAPS - 1; i++) begin
          w[i] = sample_t'(int'($urandom_range(4000)) - 2000);
          total += w[i];
        end
        w[TAPS-1] = sample_t'(-total);
      end
      3: for (int i = 0; i < TAPS; i++) w[i] = sample_t'($urandom_range(32767));
      4: for (int i = 0; i < TAPS; i++) w[i] = corner_value();
      default: begin
        // mostly negative weights with a few positive taps, usually a negative total
        for (int i = 0; i < TAPS; i++) begin
          if ($urandom_range(2) == 0) w[i] = sample_t'($urandom_range(3000));
          else w[i] = sample_t'(-int'($urandom_range(32768, 1000)));
        end
      end
    endcase
    write_all_taps(w);
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, 8)), sample_t'($urandom));
  endtask

  initial begin
    sample_t w [TAPS];
    int sent;
    int n;
    rst = 1'b1;
    steady = 1'b0;
    n_errors = 0;
    idle_cycles = 0;
    in_taken = 1'b0;
    up_if.valid = 1'b0;
    up_if.sample_in = '0;
    dn_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    for (int i = 0; i < TAPS; i++) weights[i] = '0;
    weights[0] = 16'sd1;
    for (int i = 0; i < HIST_LEN; i++) history[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset weights pass the sample straight through
    samples_to_send = '{16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000,
                        16'sh5555, 16'shaaaa};
    drain();

    // every tap at full positive scale, then zeros to flush the tail
    for (int i = 0; i < TAPS; i++) w[i] = 16'sh7fff;
    write_all_taps(w);
    samples_to_send = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'shffff,
                        16'sh0000, 16'sh0000};
    drain();

    // weights cancel: flagged, while history keeps shifting
    for (int i = 0; i < TAPS; i++) w[i] = '0;
    w[0] = 16'sd5;
    w[1] = -16'sd5;
    write_all_taps(w);
    write_reg(REG_TOP, 16'sh8000);
    write_reg(REG_PAST_LAST, 16'sd123);
    samples_to_send = '{16'sh1234, 16'sh8000, 16'sh7fff};
    drain();

    // negative total flips the sign of positive terms
    w[0] = 16'sh8000;
    w[1] = 16'sh8000;
    w[2] = 16'sd300;
    w[3] = 16'sh7fff;
    write_all_taps(w);
    samples_to_send = '{16'sh7fff, 16'sh8000, 16'sh0064, 16'shff9c};
    drain();

    sent = 0;
    n = 0;
    while (sent < RANDOM_ITEMS) begin
      random_weights();
      steady = (n == 4);
      for (int i = $urandom_range(200, 60); i > 0; i--) begin
        samples_to_send.push_back(rand_sample());
        sent++;
      end
      drain();
      n++;
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_out.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_out.size()));
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
